>>> rtl/upnm_pkg.sv
package upnm_pkg;

    // field widths of the configuration word and of the item and result beats
    localparam int CFG_W  = 6;
    localparam int IDX_W  = 5;
    localparam int POS_W  = 4;
    localparam int CHAR_W = 8;
    localparam int STAT_W = 2;

    // default sizes handed down from the top level
    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_NAME_LEN    = 16;

    // characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // action codes
    localparam logic ACT_NAME_WR  = 1'b0;
    localparam logic ACT_QUERY_WR = 1'b1;

    // match status codes
    localparam logic [STAT_W-1:0] ST_EXACT     = 2'd0;
    localparam logic [STAT_W-1:0] ST_PARTIAL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTUNIQUE = 2'd3;

    // one input beat
    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  entry_index;
        logic [POS_W-1:0]  char_position;
        logic [CHAR_W-1:0] char_value;
        logic              query_last;
    } t_in_item;

    // one result beat
    typedef struct packed {
        logic [STAT_W-1:0] match_status;
        logic [IDX_W-1:0]  match_index;
    } t_result;

    // scan status toward the top level
    typedef struct packed {
        logic    busy;
        logic    done;
        t_result res;
    } t_scan_stat;

endpackage

>>> rtl/upnm_name_ram.sv
module upnm_name_ram #(
    parameter int TABLE_DEPTH = upnm_pkg::DEF_TABLE_DEPTH,
    parameter int NAME_LEN    = upnm_pkg::DEF_NAME_LEN
) (
    input  logic                                          i_clk,
    input  logic                                          i_wr_en,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [$clog2(NAME_LEN)-1:0]                   i_wr_pos,
    input  logic [upnm_pkg::CHAR_W-1:0]                   i_wr_char,
    input  logic                                          i_rd_en,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_rd_addr,
    output logic [NAME_LEN-1:0][upnm_pkg::CHAR_W-1:0]     o_rd_data
);

    // one row per name, written one character at a time
    logic [NAME_LEN-1:0][upnm_pkg::CHAR_W-1:0] r_mem [TABLE_DEPTH];
    logic [NAME_LEN-1:0][upnm_pkg::CHAR_W-1:0] r_rd_data;

    // byte write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][i_wr_pos] <= i_wr_char;
        end
    end

    // row read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/upnm_query.sv
module upnm_query #(
    parameter int NAME_LEN = upnm_pkg::DEF_NAME_LEN
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_append,
    input  logic [upnm_pkg::CHAR_W-1:0]               i_char,
    input  logic                                      i_clear,
    output logic [NAME_LEN-1:0][upnm_pkg::CHAR_W-1:0] o_qbuf,
    output logic [NAME_LEN-1:0]                       o_qmask,
    output logic                                      o_overflow
);

    localparam int QPW = $clog2(NAME_LEN);
    localparam int QLW = $clog2(NAME_LEN + 1);
    localparam logic [QLW-1:0] LEN_MAX = QLW'(NAME_LEN);

    logic [NAME_LEN-1:0][upnm_pkg::CHAR_W-1:0] r_qbuf;
    logic [QLW-1:0]                            r_qlen;
    logic                                      r_qovf;

    // length and overflow flag; a beat taken in the result cycle starts the next query
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
            r_qovf <= 1'b0;
        end else if (i_clear) begin
            r_qlen <= i_append ? QLW'(1) : '0;
            r_qovf <= 1'b0;
        end else if (i_append) begin
            if (r_qlen < LEN_MAX) begin
                r_qlen <= r_qlen + 1'b1;
            end else begin
                r_qovf <= 1'b1;
            end
        end
    end

    // character store, extra characters dropped
    always_ff @(posedge i_clk) begin
        if (i_append && i_clear) begin
            r_qbuf[0] <= i_char;
        end else if (i_append && (r_qlen < LEN_MAX)) begin
            r_qbuf[r_qlen[QPW-1:0]] <= i_char;
        end
    end

    // positions that take part in the compare: below the length and before a nul
    always_comb begin : mask_build
        logic v_run;
        v_run = 1'b1;
        for (int i = 0; i < NAME_LEN; i++) begin
            v_run = v_run && (QLW'(i) < r_qlen) && (r_qbuf[i] != upnm_pkg::CHAR_NUL);
            o_qmask[i] = v_run;
        end
    end

    assign o_qbuf     = r_qbuf;
    assign o_overflow = r_qovf;

endmodule

>>> rtl/upnm_scan.sv
module upnm_scan #(
    parameter int TABLE_DEPTH = upnm_pkg::DEF_TABLE_DEPTH,
    parameter int NAME_LEN    = upnm_pkg::DEF_NAME_LEN
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_go,
    input  logic [upnm_pkg::CFG_W-1:0]                    i_entries,
    input  logic                                          i_overflow,
    input  logic [NAME_LEN-1:0][upnm_pkg::CHAR_W-1:0]     i_qbuf,
    input  logic [NAME_LEN-1:0]                           i_qmask,
    output logic                                          o_rd_en,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] o_rd_addr,
    input  logic [NAME_LEN-1:0][upnm_pkg::CHAR_W-1:0]     i_rd_data,
    output upnm_pkg::t_scan_stat                          o_stat
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW  = $clog2(TABLE_DEPTH + 1);
    localparam int CW  = (DW > upnm_pkg::CFG_W) ? DW : upnm_pkg::CFG_W;
    localparam int IW  = upnm_pkg::IDX_W;
    localparam int CHW = upnm_pkg::CHAR_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic              r_state, n_state;
    logic [CW-1:0]     r_limit, n_limit;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pidx, n_pidx;
    logic [1:0]        r_found, n_found;
    logic [AW-1:0]     r_first, n_first;
    logic              r_done, n_done;
    upnm_pkg::t_result r_res, n_res;

    logic [NAME_LEN-1:0] w_sel;
    logic [CHW-1:0]      w_next;
    logic                w_mism;
    logic                w_empty;
    logic                w_term;
    logic                w_hit_exact;
    logic                w_hit_partial;

    // compare the row just read against the query
    always_comb begin
        w_mism = 1'b0;
        w_next = upnm_pkg::CHAR_NUL;
        for (int i = 0; i < NAME_LEN; i++) begin
            w_sel[i] = ((i == 0) ? 1'b1 : i_qmask[(i == 0) ? 0 : i - 1]) && !i_qmask[i];
            w_mism   = w_mism || (i_qmask[i] && (i_qbuf[i] != i_rd_data[i]));
            w_next   = w_next | (w_sel[i] ? i_rd_data[i] : upnm_pkg::CHAR_NUL);
        end
    end

    assign w_empty       = (i_rd_data[0] == upnm_pkg::CHAR_NUL);
    assign w_term        = (w_next == upnm_pkg::CHAR_NUL) || (w_next == upnm_pkg::CHAR_SPACE);
    assign w_hit_exact   = r_pend && !w_empty && !w_mism && w_term;
    assign w_hit_partial = r_pend && !w_empty && !w_mism && !w_term;

    // scan sequencer: one row read per cycle, compare in the cycle after the read
    always_comb begin
        n_state   = r_state;
        n_limit   = r_limit;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_found   = r_found;
        n_first   = r_first;
        n_done    = 1'b0;
        n_res     = r_res;
        o_rd_en   = 1'b0;
        o_rd_addr = r_cnt[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    n_found = 2'd0;
                    n_first = '0;
                    n_limit = (CW'(i_entries) > DEPTH_C) ? DEPTH_C : CW'(i_entries);
                end
            end
            S_RUN: begin
                if (i_overflow) begin
                    n_state                = S_IDLE;
                    n_pend                 = 1'b0;
                    n_done                 = 1'b1;
                    n_res.match_status     = upnm_pkg::ST_NOTFOUND;
                    n_res.match_index      = '0;
                end else if (w_hit_exact) begin
                    n_state                = S_IDLE;
                    n_pend                 = 1'b0;
                    n_done                 = 1'b1;
                    n_res.match_status     = upnm_pkg::ST_EXACT;
                    n_res.match_index      = IW'(r_pidx);
                end else if (!r_pend && (r_cnt >= r_limit)) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    case (r_found)
                        2'd0: begin
                            n_res.match_status = upnm_pkg::ST_NOTFOUND;
                            n_res.match_index  = '0;
                        end
                        2'd1: begin
                            n_res.match_status = upnm_pkg::ST_PARTIAL;
                            n_res.match_index  = IW'(r_first);
                        end
                        default: begin
                            n_res.match_status = upnm_pkg::ST_NOTUNIQUE;
                            n_res.match_index  = '0;
                        end
                    endcase
                end else begin
                    // count partial hits, saturating at two
                    if (w_hit_partial) begin
                        if (r_found == 2'd0) begin
                            n_first = r_pidx;
                        end
                        if (r_found != 2'd2) begin
                            n_found = r_found + 2'd1;
                        end
                    end
                    // issue the next row read
                    if (r_cnt < r_limit) begin
                        o_rd_en = 1'b1;
                        n_pend  = 1'b1;
                        n_pidx  = r_cnt[AW-1:0];
                        n_cnt   = r_cnt + 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_limit <= '0;
            r_found <= 2'd0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            r_limit <= n_limit;
            r_found <= n_found;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx  <= n_pidx;
        r_first <= n_first;
        r_res   <= n_res;
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = r_done;
    assign o_stat.res  = r_res;

endmodule

>>> rtl/unique_prefix_name_matcher_core.sv
// Unique-prefix name matcher.
// Input beats are taken when start is high and busy is low. Action 0 writes one
// character of a table name into the name memory; action 1 appends one query
// character. Action 1 with query_last starts a search
// over entries 0 .. min(entries_in_use, TABLE_DEPTH)-1 of the name memory.
// The search reads one whole name row per cycle from the memory's single read
// port, and busy stays high while it runs; the result beat shows on o_result
// with o_result_valid high for one cycle. The search stops early on an exact
// hit or an overlong query. busy is low again in the result cycle.
// The receiver cannot stall: the result beat is there for that one cycle only.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) sets
// entries_in_use and is always ready; write it only while the block is idle.
// Reset clears the query length, the overflow flag, entries_in_use and the
// search control; the name memory holds no defined value until written.
module unique_prefix_name_matcher_core #(
    parameter int TABLE_DEPTH = upnm_pkg::DEF_TABLE_DEPTH,
    parameter int NAME_LEN    = upnm_pkg::DEF_NAME_LEN
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  upnm_pkg::t_in_item           i_item,
    output logic                         o_result_valid,
    output upnm_pkg::t_result            o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [upnm_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int QPW = $clog2(NAME_LEN);

    logic [upnm_pkg::CFG_W-1:0]                r_entries;
    logic                                      w_accept;
    logic                                      w_name_wr;
    logic                                      w_append;
    logic                                      w_go;
    logic [NAME_LEN-1:0][upnm_pkg::CHAR_W-1:0] w_qbuf;
    logic [NAME_LEN-1:0]                       w_qmask;
    logic                                      w_qovf;
    logic                                      w_rd_en;
    logic [AW-1:0]                             w_rd_addr;
    logic [NAME_LEN-1:0][upnm_pkg::CHAR_W-1:0] w_rd_data;
    upnm_pkg::t_scan_stat                      w_stat;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entries <= i_cfg_data;
        end
    end

    // input beat decode
    assign w_accept  = start && !busy;
    assign w_name_wr = w_accept && (i_item.action == upnm_pkg::ACT_NAME_WR)
                       && (32'(i_item.entry_index) < TABLE_DEPTH)
                       && (32'(i_item.char_position) < NAME_LEN);
    assign w_append  = w_accept && (i_item.action == upnm_pkg::ACT_QUERY_WR);
    assign w_go      = w_append && i_item.query_last;

    upnm_name_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_LEN    (NAME_LEN)
    ) u_name_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_name_wr),
        .i_wr_addr (AW'(i_item.entry_index)),
        .i_wr_pos  (QPW'(i_item.char_position)),
        .i_wr_char (i_item.char_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    upnm_query #(
        .NAME_LEN (NAME_LEN)
    ) u_query (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_append   (w_append),
        .i_char     (i_item.char_value),
        .i_clear    (w_stat.done),
        .o_qbuf     (w_qbuf),
        .o_qmask    (w_qmask),
        .o_overflow (w_qovf)
    );

    upnm_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_LEN    (NAME_LEN)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_entries  (r_entries),
        .i_overflow (w_qovf),
        .i_qbuf     (w_qbuf),
        .i_qmask    (w_qmask),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data),
        .o_stat     (w_stat)
    );

    // handshake and result beat
    assign busy           = w_stat.busy;
    assign o_result_valid = w_stat.done;
    assign o_result       = w_stat.res;

endmodule
